// ===== sv/bps_pkg.sv =====
// Package for the buzzer beep pattern sequencer.
// Holds command and pattern codes, fixed tone constants and the payload types.
// No dependencies.
package bps_pkg;

	// Command codes carried in the mode field
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_SINGLE = 3'd1;
	localparam logic [2:0] MODE_TRAIN  = 3'd2;
	localparam logic [2:0] MODE_TONE   = 3'd3;
	localparam logic [2:0] MODE_STOP   = 3'd4;
	localparam logic [2:0] MODE_SEQ    = 3'd5;

	// Pattern kinds
	localparam logic [1:0] PAT_IDLE    = 2'd0;
	localparam logic [1:0] PAT_ONESHOT = 2'd1;
	localparam logic [1:0] PAT_TRAIN   = 2'd2;
	localparam logic [1:0] PAT_SEQ     = 2'd3;

	// Sequence steps
	localparam logic [1:0] STEP_FIRST  = 2'd0;
	localparam logic [1:0] STEP_SECOND = 2'd1;
	localparam logic [1:0] STEP_THIRD  = 2'd2;

	// Fixed three-tone sequence
	localparam logic [15:0] SEQ_F0    = 16'd2000;
	localparam logic [15:0] SEQ_F1    = 16'd2600;
	localparam logic [15:0] SEQ_F2    = 16'd3200;
	localparam logic [15:0] SEQ_GAP   = 16'd120;
	localparam logic [15:0] SEQ_LONG  = 16'd200;
	localparam logic [15:0] SEQ_SHORT = 16'd100;
	localparam logic [15:0] SEQ_WAIT_EARLY = SEQ_SHORT + SEQ_GAP;
	localparam logic [15:0] SEQ_WAIT_LAST  = SEQ_LONG + SEQ_SHORT;

	// Reset values
	localparam logic [15:0] FREQ_RST = 16'd2400;
	localparam logic [15:0] ON_RST   = 16'd200;
	localparam logic [15:0] OFF_RST  = 16'd100;

	localparam logic [15:0] MS_MAX   = 16'hFFFF;
	localparam logic [7:0]  BEEP_MAX = 8'hFF;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] tone_freq;
		logic [15:0] on_time;
		logic [15:0] off_time;
		logic [7:0]  beep_total;
	} cmd_t;

	typedef struct packed {
		logic        tone_on;
		logic [15:0] sound_freq;
		logic        busy_res;
		logic [1:0]  pattern_kind;
	} status_t;

endpackage

// ===== sv/bps_stream_if.sv =====
// Valid/ready channel interface used by the beep pattern sequencer.
// Payload type is a parameter; depends on nothing else.
interface bps_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/buzzer_beep_pattern_sequencer_unit.sv =====
// Top level of the buzzer beep pattern sequencer.
// Depends on bps_pkg, bps_stream_if and bps_engine.
//
// Usage:
//   cmd    : one transaction per command or per one-millisecond tick
//            (mode 0 tick, 1 single beep, 2 beep train, 3 tone, 4 stop,
//            5 three-tone sequence; unused codes report the state as is).
//   status : exactly one transaction per cmd transaction, in order, giving
//            tone enable, frequency, busy flag and pattern kind after it.
//   Path:  a result passes through the input register, then the result
//            register, before it is offered on status.
//   Throughput: one transaction per cycle while status is ready; the pattern
//            update is a single pass of next-state logic between the two registers.
//   Stall: while status is held, the result register keeps its transaction
//            and the input register takes one more; cmd.ready drops only
//            when both are full.
//   Reset: no pattern, tone off, frequency 2400 Hz, on time 200 ms,
//            gap 100 ms; both registers empty.
module buzzer_beep_pattern_sequencer_unit (
	input  logic         clk,
	input  logic         arst_n,
	bps_stream_if.sink   cmd,
	bps_stream_if.source status
);

	logic             valid_s1;
	bps_pkg::cmd_t    cmd_s1;
	logic             valid_s2;
	bps_pkg::status_t status_s2;
	bps_pkg::status_t status_nxt;
	logic             adv_s1;

	// Stage 1 moves on when the result register is free or being drained
	assign adv_s1    = valid_s1 && (!valid_s2 || status.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
	end

	bps_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (adv_s1),
		.cmd_in     (cmd_s1),
		.status_nxt (status_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || status.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= status_nxt;
		end
	end

	assign status.valid = valid_s2;
	assign status.data  = status_s2;

endmodule

// ===== sv/bps_engine.sv =====
// Pattern state and next-state logic of the beep pattern sequencer.
// Depends on bps_pkg for codes, constants and payload types.
module bps_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  bps_pkg::cmd_t    cmd_in,
	output bps_pkg::status_t status_nxt
);

	logic [1:0]  pattern_q, pattern_d;
	logic        active_q, active_d;
	logic        phase_on_q, phase_on_d;
	logic [15:0] freq_q, freq_d;
	logic [15:0] on_q, on_d;
	logic [15:0] off_q, off_d;
	logic [15:0] phase_ms_q, phase_ms_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  done_q, done_d;
	logic [1:0]  step_q, step_d;
	logic [15:0] seq_ms_q, seq_ms_d;

	logic [15:0] phase_inc, seq_inc, seq_wait;
	logic [1:0]  step_inc;

	// Saturating millisecond counters and the sequence step wait
	assign phase_inc = (phase_ms_q == bps_pkg::MS_MAX) ? phase_ms_q : phase_ms_q + 16'd1;
	assign seq_inc   = (seq_ms_q == bps_pkg::MS_MAX) ? seq_ms_q : seq_ms_q + 16'd1;
	assign seq_wait  = (step_q >= bps_pkg::STEP_THIRD) ? bps_pkg::SEQ_WAIT_LAST
	                                                    : bps_pkg::SEQ_WAIT_EARLY;
	assign step_inc  = step_q + 2'd1;

	// Next state for one transaction
	always_comb begin
		pattern_d  = pattern_q;
		active_d   = active_q;
		phase_on_d = phase_on_q;
		freq_d     = freq_q;
		on_d       = on_q;
		off_d      = off_q;
		phase_ms_d = phase_ms_q;
		count_d    = count_q;
		done_d     = done_q;
		step_d     = step_q;
		seq_ms_d   = seq_ms_q;
		case (cmd_in.mode)
			bps_pkg::MODE_TICK: begin
				if (active_q) begin
					case (pattern_q)
						bps_pkg::PAT_SEQ: begin
							seq_ms_d   = seq_inc;
							phase_ms_d = phase_inc;
							if (seq_inc >= seq_wait) begin
								step_d   = step_inc;
								seq_ms_d = '0;
								if (step_inc == bps_pkg::STEP_SECOND) begin
									freq_d     = bps_pkg::SEQ_F1;
									on_d       = bps_pkg::SEQ_SHORT;
									phase_ms_d = '0;
									phase_on_d = 1'b1;
								end else if (step_inc == bps_pkg::STEP_THIRD) begin
									freq_d     = bps_pkg::SEQ_F2;
									on_d       = bps_pkg::SEQ_LONG;
									phase_ms_d = '0;
									phase_on_d = 1'b1;
								end else begin
									active_d   = 1'b0;
									pattern_d  = bps_pkg::PAT_IDLE;
									phase_on_d = 1'b0;
									step_d     = bps_pkg::STEP_FIRST;
								end
							end else if (phase_on_q && phase_inc >= on_q) begin
								phase_on_d = 1'b0;
							end
						end
						bps_pkg::PAT_ONESHOT: begin
							phase_ms_d = phase_inc;
							if (phase_inc >= on_q) begin
								active_d   = 1'b0;
								pattern_d  = bps_pkg::PAT_IDLE;
								phase_on_d = 1'b0;
								step_d     = bps_pkg::STEP_FIRST;
							end
						end
						bps_pkg::PAT_TRAIN: begin
							if (count_q != 8'd0 && done_q >= count_q) begin
								// counted train finished: stop without the last gap
								active_d   = 1'b0;
								pattern_d  = bps_pkg::PAT_IDLE;
								phase_on_d = 1'b0;
								step_d     = bps_pkg::STEP_FIRST;
							end else begin
								phase_ms_d = phase_inc;
								if (phase_on_q && phase_inc >= on_q) begin
									phase_on_d = 1'b0;
									phase_ms_d = '0;
									if (count_q != 8'd0 && done_q < bps_pkg::BEEP_MAX)
										done_d = done_q + 8'd1;
								end else if (!phase_on_q && phase_inc >= off_q) begin
									phase_on_d = 1'b1;
									phase_ms_d = '0;
								end
							end
						end
						default: begin
							// continuous tone: ticks leave it alone
						end
					endcase
				end
			end
			bps_pkg::MODE_SINGLE: begin
				pattern_d  = bps_pkg::PAT_ONESHOT;
				count_d    = 8'd1;
				done_d     = '0;
				freq_d     = cmd_in.tone_freq;
				on_d       = cmd_in.on_time;
				phase_ms_d = '0;
				phase_on_d = 1'b1;
				active_d   = 1'b1;
			end
			bps_pkg::MODE_TRAIN: begin
				pattern_d  = bps_pkg::PAT_TRAIN;
				off_d      = cmd_in.off_time;
				count_d    = cmd_in.beep_total;
				done_d     = '0;
				freq_d     = cmd_in.tone_freq;
				on_d       = cmd_in.on_time;
				phase_ms_d = '0;
				phase_on_d = 1'b1;
				active_d   = 1'b1;
			end
			bps_pkg::MODE_TONE: begin
				pattern_d  = bps_pkg::PAT_IDLE;
				freq_d     = cmd_in.tone_freq;
				phase_on_d = 1'b1;
				active_d   = 1'b1;
				step_d     = bps_pkg::STEP_FIRST;
			end
			bps_pkg::MODE_STOP: begin
				active_d   = 1'b0;
				pattern_d  = bps_pkg::PAT_IDLE;
				phase_on_d = 1'b0;
				step_d     = bps_pkg::STEP_FIRST;
			end
			bps_pkg::MODE_SEQ: begin
				pattern_d  = bps_pkg::PAT_SEQ;
				step_d     = bps_pkg::STEP_FIRST;
				seq_ms_d   = '0;
				freq_d     = bps_pkg::SEQ_F0;
				on_d       = bps_pkg::SEQ_SHORT;
				phase_ms_d = '0;
				phase_on_d = 1'b1;
				active_d   = 1'b1;
			end
			default: begin
				// unused codes leave the state unchanged
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= bps_pkg::PAT_IDLE;
			active_q   <= 1'b0;
			phase_on_q <= 1'b0;
			freq_q     <= bps_pkg::FREQ_RST;
			on_q       <= bps_pkg::ON_RST;
			off_q      <= bps_pkg::OFF_RST;
			phase_ms_q <= '0;
			count_q    <= '0;
			done_q     <= '0;
			step_q     <= bps_pkg::STEP_FIRST;
			seq_ms_q   <= '0;
		end else if (step_en) begin
			pattern_q  <= pattern_d;
			active_q   <= active_d;
			phase_on_q <= phase_on_d;
			freq_q     <= freq_d;
			on_q       <= on_d;
			off_q      <= off_d;
			phase_ms_q <= phase_ms_d;
			count_q    <= count_d;
			done_q     <= done_d;
			step_q     <= step_d;
			seq_ms_q   <= seq_ms_d;
		end
	end

	// Status after this transaction
	assign status_nxt.tone_on      = phase_on_d;
	assign status_nxt.sound_freq   = freq_d;
	assign status_nxt.busy_res     = active_d;
	assign status_nxt.pattern_kind = pattern_d;

endmodule
